@@ design/lbcl_pkg.sv @@
package lbcl_pkg;

  localparam int DIR_W       = 16;
  localparam int DEN_W       = DIR_W + 1;
  localparam int COORD_W_DEF = 24;
  localparam int LEN_W       = 24;
  localparam int NUM_FACES   = 6;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = ((LEN_W + NUM_FACES + 1 + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd5;

  // axis of each face, and the two axes that follow an axis
  localparam logic [1:0] FACE_AX [NUM_FACES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] AX_NEXT [3] = '{2'd1, 2'd2, 2'd0};
  localparam logic [1:0] AX_NEXT2 [3] = '{2'd2, 2'd0, 2'd1};

  typedef struct packed {
    logic [NUM_FACES-1:0] faces_hit;
    logic                 chord_valid;
  } lbcl_stat_t;

endpackage

@@ design/line_box_chord_length_top.sv @@
// throughput: one beat per cycle while out_tready is high or the output is empty;
// every stage moves on a single pipeline enable
// the long parts are the bit-per-stage quotient and square-root pipelines
// reset: synchronous, active low; clears all valid flags and the six box bounds to 0
module line_box_chord_length_top
  import lbcl_pkg::*;
#(
  parameter int COORD_W = COORD_W_DEF,
  localparam int IN_W = ((3 * DIR_W + 3 * COORD_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // dir_x, dir_y, dir_z, point_x, point_y, point_z
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // chord_length, faces_hit, chord_valid
  output logic [OUT_W-1:0]     out_tdata
);

  localparam int PW     = COORD_W + DIR_W + 1;
  localparam int QUO_W  = COORD_W + 1;
  localparam int SUM_W  = 2 * COORD_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SIDE_W = $bits(lbcl_stat_t) + 1 + 4 + 6 * COORD_W;
  localparam int CMP_W  = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;

  logic                      en;
  logic signed [COORD_W-1:0] box_r [NUM_REGS];
  logic signed [COORD_W-1:0] box_hi [3];
  logic signed [COORD_W-1:0] box_lo [3];
  logic signed [DIR_W-1:0]   in_dir [3];
  logic signed [COORD_W-1:0] in_pnt [3];

  logic                      hit_vld;
  lbcl_stat_t                hit_stat;
  logic                      hit_two;
  logic [1:0]                hit_ax [2];
  logic signed [COORD_W-1:0] hit_bnd [2];
  logic signed [COORD_W-1:0] hit_base [4];
  logic [PW-1:0]             hit_num [4];
  logic [DEN_W-1:0]          hit_den [4];
  logic                      hit_neg [4];
  logic signed [QUO_W:0]     quo [4];

  logic [SIDE_W-1:0]         side_in, side_out;
  logic                      d_vld;
  lbcl_stat_t                d_stat;
  logic                      d_two;
  logic [1:0]                d_ax [2];
  logic signed [COORD_W-1:0] d_bnd [2];
  logic signed [COORD_W-1:0] d_base [4];

  logic                      dist_vld;
  lbcl_stat_t                dist_stat;
  logic [SUM_W-1:0]          dist_sum;
  logic                      sq_vld;
  lbcl_stat_t                sq_stat;
  logic [ROOT_W-1:0]         sq_root;
  logic [CMP_W-1:0]          root_ext;
  logic [LEN_W-1:0]          len;

  logic                      out_vld_r;
  logic [OUT_W-1:0]          out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        box_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
      box_r[cfg_idx] <= cfg_data;
    end
  end

  assign box_hi = '{box_r[REG_MAX_X], box_r[REG_MAX_Y], box_r[REG_MAX_Z]};
  assign box_lo = '{box_r[REG_MIN_X], box_r[REG_MIN_Y], box_r[REG_MIN_Z]};

  assign in_dir = '{in_tdata[DIR_W-1:0], in_tdata[2*DIR_W-1:DIR_W],
                    in_tdata[3*DIR_W-1:2*DIR_W]};
  assign in_pnt = '{in_tdata[3*DIR_W +: COORD_W],
                    in_tdata[3*DIR_W+COORD_W +: COORD_W],
                    in_tdata[3*DIR_W+2*COORD_W +: COORD_W]};

  lbcl_hit #(
    .COORD_W (COORD_W)
  ) u_hit (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_dir   (in_dir),
    .in_pnt   (in_pnt),
    .box_hi   (box_hi),
    .box_lo   (box_lo),
    .out_vld  (hit_vld),
    .out_stat (hit_stat),
    .out_two  (hit_two),
    .out_ax   (hit_ax),
    .out_bnd  (hit_bnd),
    .out_base (hit_base),
    .out_num  (hit_num),
    .out_den  (hit_den),
    .out_neg  (hit_neg)
  );

  for (genvar j = 0; j < 4; j++) begin : g_div
    lbcl_div #(
      .NUM_W (PW),
      .QUO_W (QUO_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (hit_num[j]),
      .den (hit_den[j]),
      .neg (hit_neg[j]),
      .quo (quo[j])
    );
  end

  assign side_in = {hit_stat, hit_two, hit_ax[1], hit_ax[0], hit_bnd[1], hit_bnd[0],
                    hit_base[3], hit_base[2], hit_base[1], hit_base[0]};

  lbcl_dly #(
    .WIDTH (SIDE_W),
    .DEPTH (QUO_W + 1)
  ) u_dly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (hit_vld),
    .in_data  (side_in),
    .out_vld  (d_vld),
    .out_data (side_out)
  );

  assign {d_stat, d_two, d_ax[1], d_ax[0], d_bnd[1], d_bnd[0],
          d_base[3], d_base[2], d_base[1], d_base[0]} = side_out;

  lbcl_dist #(
    .COORD_W (COORD_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld),
    .in_stat  (d_stat),
    .in_two   (d_two),
    .in_ax    (d_ax),
    .in_bnd   (d_bnd),
    .in_base  (d_base),
    .in_quo   (quo),
    .out_vld  (dist_vld),
    .out_stat (dist_stat),
    .out_sum  (dist_sum)
  );

  lbcl_sqrt #(
    .RAD_W (SUM_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dist_vld),
    .in_stat  (dist_stat),
    .in_rad   (dist_sum),
    .out_vld  (sq_vld),
    .out_stat (sq_stat),
    .out_root (sq_root)
  );

  // saturate the length
  assign root_ext = CMP_W'(sq_root);
  assign len = (root_ext > CMP_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : root_ext[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({sq_stat.chord_valid, sq_stat.faces_hit, len});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/lbcl_hit.sv @@
module lbcl_hit
  import lbcl_pkg::*;
#(
  parameter int COORD_W = COORD_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [DIR_W-1:0]        in_dir [3],
  input  logic signed [COORD_W-1:0]      in_pnt [3],
  input  logic signed [COORD_W-1:0]      box_hi [3],
  input  logic signed [COORD_W-1:0]      box_lo [3],
  output logic                           out_vld,
  output lbcl_stat_t                     out_stat,
  output logic                           out_two,
  output logic [1:0]                     out_ax [2],
  output logic signed [COORD_W-1:0]      out_bnd [2],
  output logic signed [COORD_W-1:0]      out_base [4],
  output logic [COORD_W+DIR_W:0]         out_num [4],
  output logic [DEN_W-1:0]               out_den [4],
  output logic                           out_neg [4]
);

  localparam int DW = COORD_W + 1;
  localparam int PW = COORD_W + DIR_W + 1;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [DIR_W-1:0]   dir1_r [3];
  logic signed [DIR_W-1:0]   dir2_r [3];
  logic signed [DIR_W-1:0]   dir3_r [3];
  logic signed [COORD_W-1:0] pnt1_r [3];
  logic signed [COORD_W-1:0] pnt2_r [3];
  logic signed [COORD_W-1:0] pnt3_r [3];
  logic signed [COORD_W-1:0] bound [NUM_FACES];
  logic signed [DW-1:0]      d_r [NUM_FACES];
  logic signed [DW-1:0]      rlo_r [3];
  logic signed [DW-1:0]      rhi_r [3];
  logic signed [PW-1:0]      nb_r [NUM_FACES];
  logic signed [PW-1:0]      nc_r [NUM_FACES];
  logic signed [PW-1:0]      lob_r [3];
  logic signed [PW-1:0]      hib_r [3];
  logic signed [PW-1:0]      loc_r [3];
  logic signed [PW-1:0]      hic_r [3];

  lbcl_stat_t                stat_nxt, stat4_r, stat5_r;
  logic                      two_nxt, two4_r, two5_r;
  logic [1:0]                ax_nxt [2];
  logic [1:0]                ax4_r [2];
  logic [1:0]                ax5_r [2];
  logic signed [COORD_W-1:0] bnd_nxt [2];
  logic signed [COORD_W-1:0] bnd4_r [2];
  logic signed [COORD_W-1:0] bnd5_r [2];
  logic signed [PW-1:0]      numb_nxt [2];
  logic signed [PW-1:0]      numc_nxt [2];
  logic signed [PW-1:0]      numb4_r [2];
  logic signed [PW-1:0]      numc4_r [2];
  logic signed [DIR_W-1:0]   ma_nxt [2];
  logic signed [DIR_W-1:0]   ma4_r [2];
  logic signed [COORD_W-1:0] bb_nxt [2];
  logic signed [COORD_W-1:0] bc_nxt [2];
  logic signed [COORD_W-1:0] bb4_r [2];
  logic signed [COORD_W-1:0] bc4_r [2];
  logic signed [COORD_W-1:0] base5_r [4];
  logic [PW-1:0]             num_nxt [4];
  logic [PW-1:0]             num5_r [4];
  logic [DEN_W-1:0]          den_nxt [4];
  logic [DEN_W-1:0]          den5_r [4];
  logic                      neg_nxt [4];
  logic                      neg5_r [4];

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      bound[f] = (f % 2 == 0) ? box_hi[FACE_AX[f]] : box_lo[FACE_AX[f]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // offsets to the face planes and products for the exact inside tests
  always_ff @(posedge clk) begin
    if (en) begin
      dir1_r <= in_dir;
      pnt1_r <= in_pnt;
      dir2_r <= dir1_r;
      pnt2_r <= pnt1_r;
      dir3_r <= dir2_r;
      pnt3_r <= pnt2_r;
      for (int f = 0; f < NUM_FACES; f++) begin
        d_r[f]  <= DW'(bound[f]) - DW'(pnt1_r[FACE_AX[f]]);
        nb_r[f] <= PW'(dir2_r[AX_NEXT[FACE_AX[f]]]) * PW'(d_r[f]);
        nc_r[f] <= PW'(dir2_r[AX_NEXT2[FACE_AX[f]]]) * PW'(d_r[f]);
      end
      for (int k = 0; k < 3; k++) begin
        rlo_r[k] <= DW'(box_lo[k]) - DW'(pnt1_r[k]);
        rhi_r[k] <= DW'(box_hi[k]) - DW'(pnt1_r[k]);
        lob_r[k] <= PW'(rlo_r[AX_NEXT[k]]) * PW'(dir2_r[k]);
        hib_r[k] <= PW'(rhi_r[AX_NEXT[k]]) * PW'(dir2_r[k]);
        loc_r[k] <= PW'(rlo_r[AX_NEXT2[k]]) * PW'(dir2_r[k]);
        hic_r[k] <= PW'(rhi_r[AX_NEXT2[k]]) * PW'(dir2_r[k]);
      end
    end
  end

  // face hits and selection of the first two
  always_comb begin
    logic       inb;
    logic       inc;
    logic [2:0] cnt;
    logic [1:0] a;
    cnt = '0;
    stat_nxt = '0;
    for (int p = 0; p < 2; p++) begin
      ax_nxt[p]   = '0;
      bnd_nxt[p]  = '0;
      numb_nxt[p] = '0;
      numc_nxt[p] = '0;
      ma_nxt[p]   = '0;
      bb_nxt[p]   = '0;
      bc_nxt[p]   = '0;
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      a = FACE_AX[f];
      if (dir3_r[a] > 0) begin
        inb = (nb_r[f] > lob_r[a]) && (nb_r[f] < hib_r[a]);
        inc = (nc_r[f] > loc_r[a]) && (nc_r[f] < hic_r[a]);
      end else begin
        inb = (nb_r[f] < lob_r[a]) && (nb_r[f] > hib_r[a]);
        inc = (nc_r[f] < loc_r[a]) && (nc_r[f] > hic_r[a]);
      end
      if ((dir3_r[a] != '0) && inb && inc) begin
        stat_nxt.faces_hit[f] = 1'b1;
        if (cnt < 3'd2) begin
          ax_nxt[cnt[0]]   = a;
          bnd_nxt[cnt[0]]  = bound[f];
          numb_nxt[cnt[0]] = nb_r[f];
          numc_nxt[cnt[0]] = nc_r[f];
          ma_nxt[cnt[0]]   = dir3_r[a];
          bb_nxt[cnt[0]]   = pnt3_r[AX_NEXT[a]];
          bc_nxt[cnt[0]]   = pnt3_r[AX_NEXT2[a]];
        end
        cnt = cnt + 3'd1;
      end
    end
    stat_nxt.chord_valid = (cnt == 3'd2);
    two_nxt = (cnt >= 3'd2);
  end

  // divider operands: rounded quotient is (2|num| + |ma|) / (2|ma|)
  always_comb begin
    logic signed [PW-1:0]    num;
    logic signed [DIR_W-1:0] ma;
    logic [PW-1:0]           amag;
    logic [DIR_W-1:0]        bmag;
    for (int j = 0; j < 4; j++) begin
      num  = j[0] ? numc4_r[j >> 1] : numb4_r[j >> 1];
      ma   = ma4_r[j >> 1];
      amag = num[PW-1] ? PW'(-num) : PW'(num);
      bmag = ma[DIR_W-1] ? DIR_W'(-ma) : DIR_W'(ma);
      num_nxt[j] = (amag << 1) + PW'(bmag);
      den_nxt[j] = {bmag, 1'b0};
      neg_nxt[j] = num[PW-1] ^ ma[DIR_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stat4_r  <= stat_nxt;
      two4_r   <= two_nxt;
      ax4_r    <= ax_nxt;
      bnd4_r   <= bnd_nxt;
      numb4_r  <= numb_nxt;
      numc4_r  <= numc_nxt;
      ma4_r    <= ma_nxt;
      bb4_r    <= bb_nxt;
      bc4_r    <= bc_nxt;
      stat5_r  <= stat4_r;
      two5_r   <= two4_r;
      ax5_r    <= ax4_r;
      bnd5_r   <= bnd4_r;
      base5_r  <= '{bb4_r[0], bc4_r[0], bb4_r[1], bc4_r[1]};
      num5_r   <= num_nxt;
      den5_r   <= den_nxt;
      neg5_r   <= neg_nxt;
    end
  end

  assign out_vld  = v5_r;
  assign out_stat = stat5_r;
  assign out_two  = two5_r;
  assign out_ax   = ax5_r;
  assign out_bnd  = bnd5_r;
  assign out_base = base5_r;
  assign out_num  = num5_r;
  assign out_den  = den5_r;
  assign out_neg  = neg5_r;

endmodule

@@ design/lbcl_div.sv @@
module lbcl_div
  import lbcl_pkg::*;
#(
  parameter int NUM_W = COORD_W_DEF + DIR_W + 1,
  parameter int QUO_W = COORD_W_DEF + 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  input  logic                  neg,
  output logic signed [QUO_W:0] quo
);

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] q_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic             neg_r [QUO_W];
  logic [NUM_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] q_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic             neg_in [QUO_W];
  logic [NUM_W-1:0] trial [QUO_W];
  logic             take [QUO_W];
  logic [NUM_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] q_nxt [QUO_W];
  logic signed [QUO_W:0] qs;
  logic signed [QUO_W:0] quo_r;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int POS = QUO_W - 1 - i;
    if (i == 0) begin : g_first
      assign rem_in[i] = num;
      assign q_in[i]   = '0;
      assign den_in[i] = den;
      assign neg_in[i] = neg;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign q_in[i]   = q_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign neg_in[i] = neg_r[i-1];
    end
    assign trial[i]   = NUM_W'(den_in[i]) << POS;
    assign take[i]    = rem_in[i] >= trial[i];
    assign rem_nxt[i] = take[i] ? rem_in[i] - trial[i] : rem_in[i];
    assign q_nxt[i]   = q_in[i] | (take[i] ? (QUO_W'(1) << POS) : '0);
  end

  assign qs = $signed({1'b0, q_r[QUO_W-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_r[i] <= rem_nxt[i];
        q_r[i]   <= q_nxt[i];
        den_r[i] <= den_in[i];
        neg_r[i] <= neg_in[i];
      end
      quo_r <= neg_r[QUO_W-1] ? -qs : qs;
    end
  end

  assign quo = quo_r;

endmodule

@@ design/lbcl_dly.sv @@
module lbcl_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_vld,
  output logic [WIDTH-1:0] out_data
);

  logic             vld_r [DEPTH];
  logic [WIDTH-1:0] data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = data_r[DEPTH-1];

endmodule

@@ design/lbcl_dist.sv @@
module lbcl_dist
  import lbcl_pkg::*;
#(
  parameter int COORD_W = COORD_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  lbcl_stat_t                in_stat,
  input  logic                      in_two,
  input  logic [1:0]                in_ax [2],
  input  logic signed [COORD_W-1:0] in_bnd [2],
  input  logic signed [COORD_W-1:0] in_base [4],
  input  logic signed [COORD_W+1:0] in_quo [4],
  output logic                      out_vld,
  output lbcl_stat_t                out_stat,
  output logic [2*COORD_W+1:0]      out_sum
);

  localparam int SQ_W  = 2 * COORD_W;
  localparam int SUM_W = 2 * COORD_W + 2;

  logic                      va_r, vb_r, vc_r, vd_r;
  lbcl_stat_t                sa_r, sb_r, sc_r, sd_r;
  logic                      ta_r, tb_r, tc_r;
  logic signed [COORD_W+1:0] crd [4];
  logic signed [COORD_W-1:0] pt_nxt [2][3];
  logic signed [COORD_W-1:0] pt_r [2][3];
  logic signed [COORD_W:0]   diff_r [3];
  logic signed [SUM_W-1:0]   prod [3];
  logic [SQ_W-1:0]           sq_r [3];
  logic [SUM_W-1:0]          sum_r;

  // hit points back in x, y, z order
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      crd[j] = (COORD_W+2)'(in_base[j]) + in_quo[j];
    end
    for (int p = 0; p < 2; p++) begin
      for (int k = 0; k < 3; k++) begin
        if (in_ax[p] == 2'(k)) begin
          pt_nxt[p][k] = in_bnd[p];
        end else if (in_ax[p] == AX_NEXT2[k]) begin
          pt_nxt[p][k] = crd[2*p][COORD_W-1:0];
        end else begin
          pt_nxt[p][k] = crd[2*p+1][COORD_W-1:0];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      prod[k] = SUM_W'(diff_r[k]) * SUM_W'(diff_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= in_stat;
      sb_r <= sa_r;
      sc_r <= sb_r;
      sd_r <= sc_r;
      ta_r <= in_two;
      tb_r <= ta_r;
      tc_r <= tb_r;
      pt_r <= pt_nxt;
      for (int k = 0; k < 3; k++) begin
        diff_r[k] <= (COORD_W+1)'(pt_r[0][k]) - (COORD_W+1)'(pt_r[1][k]);
        sq_r[k]   <= prod[k][SQ_W-1:0];
      end
      sum_r <= tc_r ? SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) : '0;
    end
  end

  assign out_vld  = vd_r;
  assign out_stat = sd_r;
  assign out_sum  = sum_r;

endmodule

@@ design/lbcl_sqrt.sv @@
module lbcl_sqrt
  import lbcl_pkg::*;
#(
  parameter int RAD_W = 2 * COORD_W_DEF + 2,
  localparam int ROOT_W = RAD_W / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  lbcl_stat_t        in_stat,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_vld,
  output lbcl_stat_t        out_stat,
  output logic [ROOT_W-1:0] out_root
);

  logic              vld_r [ROOT_W];
  lbcl_stat_t        stat_r [ROOT_W];
  logic [RAD_W-1:0]  rem_r [ROOT_W];
  logic [ROOT_W-1:0] res_r [ROOT_W];
  logic [RAD_W-1:0]  rem_in [ROOT_W];
  logic [ROOT_W-1:0] res_in [ROOT_W];
  logic [RAD_W:0]    trial [ROOT_W];
  logic              take [ROOT_W];
  logic [RAD_W-1:0]  rem_nxt [ROOT_W];
  logic [ROOT_W-1:0] res_nxt [ROOT_W];

  // one root bit per stage, remainder kept as rad - res^2
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int POS = ROOT_W - 1 - i;
    if (i == 0) begin : g_first
      assign rem_in[i] = in_rad;
      assign res_in[i] = '0;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign res_in[i] = res_r[i-1];
    end
    assign trial[i]   = ((RAD_W+1)'(res_in[i]) << (POS + 1)) |
                        ((RAD_W+1)'(1) << (2 * POS));
    assign take[i]    = {1'b0, rem_in[i]} >= trial[i];
    assign rem_nxt[i] = take[i] ? RAD_W'({1'b0, rem_in[i]} - trial[i]) : rem_in[i];
    assign res_nxt[i] = res_in[i] | (take[i] ? (ROOT_W'(1) << POS) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < ROOT_W; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stat_r[0] <= in_stat;
      for (int i = 1; i < ROOT_W; i++) begin
        stat_r[i] <= stat_r[i-1];
      end
      for (int i = 0; i < ROOT_W; i++) begin
        rem_r[i] <= rem_nxt[i];
        res_r[i] <= res_nxt[i];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_stat = stat_r[ROOT_W-1];
  assign out_root = res_r[ROOT_W-1];

endmodule
